// ===== rtl/sacl_pkg.sv =====
// Package for the set-associative cache with saturating age counters.
// Holds geometry constants and the per-way state record; no dependencies.
package sacl_pkg;

	localparam int SETS           = 256;
	localparam int WAYS           = 4;
	localparam int WORDS_PER_LINE = 8;
	localparam int ADDR_W         = 32;
	localparam int DATA_W         = 32;
	localparam int PEN_W          = 10;
	localparam int IDX_W          = $clog2(SETS);
	localparam int OFF_W          = $clog2(WORDS_PER_LINE);
	localparam int WAY_W          = 2;
	localparam int AGE_W          = $clog2(WAYS);
	localparam int TAG_W          = ADDR_W - 2 - OFF_W - IDX_W;
	localparam int DROW_W         = IDX_W + OFF_W;
	localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);
	localparam logic [PEN_W-1:0] PENALTY_RESET = PEN_W'(50);

	typedef struct packed {
		logic                      valid;
		logic                      dirty;
		logic [AGE_W-1:0]          age;
		logic [WORDS_PER_LINE-1:0] filled;
		logic [TAG_W-1:0]          tag;
	} way_entry_t;

	typedef way_entry_t [WAYS-1:0] set_row_t;
	typedef logic [WAYS-1:0][DATA_W-1:0] data_row_t;

endpackage

// ===== rtl/sacl_tag_ram.sv =====
// Set state memory: one row per set with tag, marks, ages and word fill bits.
// Depends on sacl_pkg.
module sacl_tag_ram (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [sacl_pkg::IDX_W-1:0] rd_addr,
	output sacl_pkg::set_row_t         rd_data,
	input  logic                       wr_en,
	input  logic [sacl_pkg::IDX_W-1:0] wr_addr,
	input  sacl_pkg::set_row_t         wr_data
);

	sacl_pkg::set_row_t mem [sacl_pkg::SETS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/sacl_data_ram.sv =====
// Line word memory: one row per set and word offset, one lane per way.
// Depends on sacl_pkg.
module sacl_data_ram (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [sacl_pkg::DROW_W-1:0] rd_addr,
	output sacl_pkg::data_row_t         rd_data,
	input  logic                        wr_en,
	input  logic [sacl_pkg::WAYS-1:0]   wr_lanes,
	input  logic [sacl_pkg::DROW_W-1:0] wr_addr,
	input  logic [sacl_pkg::DATA_W-1:0] wr_data
);

	sacl_pkg::data_row_t mem [sacl_pkg::SETS * sacl_pkg::WORDS_PER_LINE];

	always_ff @(posedge clk) begin
		for (int w = 0; w < sacl_pkg::WAYS; w++) begin
			if (wr_en && wr_lanes[w]) begin
				mem[wr_addr][w] <= wr_data;
			end
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/set_assoc_cache_lru_counters.sv =====
// Top level of the set-associative write-back cache with age counters.
// Depends on sacl_pkg, sacl_tag_ram and sacl_data_ram.
//
// An access is taken when start is high and busy is low; its result is
// registered in the look state, shown for one cycle with done high, and
// cannot be stalled. The set row and the four way lanes of the word are read
// in the accept cycle; the updated row, and the word on a write, are written
// back at the end of the next. After reset a clearing pass over all 256 sets,
// one set a cycle, holds busy high. Configuration beats are taken at any time.
module set_assoc_cache_lru_counters (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [sacl_pkg::ADDR_W-1:0]   address,
	input  logic [sacl_pkg::DATA_W-1:0]   write_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sacl_pkg::PEN_W-1:0]    cfg_data,
	output logic                          done,
	output logic [sacl_pkg::DATA_W-1:0]   read_data,
	output logic                          hit,
	output logic [sacl_pkg::WAY_W-1:0]    chosen_way,
	output logic                          writeback,
	output logic [sacl_pkg::ADDR_W-1:0]   writeback_addr,
	output logic [sacl_pkg::ADDR_W-1:0]   time_total
);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_LOOK  = 3'b100
	} state_t;

	state_t                          state_q;
	logic [sacl_pkg::IDX_W-1:0]      clr_idx_q;
	logic [sacl_pkg::PEN_W-1:0]      penalty_q;
	logic [sacl_pkg::ADDR_W-1:0]     sum_q;

	logic                            op_s1;
	logic [sacl_pkg::TAG_W-1:0]      tag_s1;
	logic [sacl_pkg::IDX_W-1:0]      idx_s1;
	logic [sacl_pkg::OFF_W-1:0]      off_s1;
	logic [sacl_pkg::DATA_W-1:0]     wdata_s1;

	logic                            accept;
	logic [sacl_pkg::TAG_W-1:0]      in_tag;
	logic [sacl_pkg::IDX_W-1:0]      in_idx;
	logic [sacl_pkg::OFF_W-1:0]      in_off;

	sacl_pkg::set_row_t              row;
	sacl_pkg::set_row_t              new_row;
	sacl_pkg::data_row_t             drow;

	logic                            is_hit;
	logic                            found;
	logic [sacl_pkg::WAY_W-1:0]      hit_way;
	logic [sacl_pkg::WAY_W-1:0]      vic_way;
	logic [sacl_pkg::WAY_W-1:0]      way;
	logic [sacl_pkg::AGE_W-1:0]      least;
	logic                            wb;
	logic [sacl_pkg::DATA_W-1:0]     rdata;
	logic [sacl_pkg::WAYS-1:0]       lanes;

	logic                            tag_wr_en;
	logic [sacl_pkg::IDX_W-1:0]      tag_wr_addr;
	sacl_pkg::set_row_t              tag_wr_data;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_off    = address[2 +: sacl_pkg::OFF_W];
	assign in_idx    = address[2 + sacl_pkg::OFF_W +: sacl_pkg::IDX_W];
	assign in_tag    = address[sacl_pkg::ADDR_W-1 -: sacl_pkg::TAG_W];

	always_comb begin
		is_hit  = 1'b0;
		hit_way = '0;
		for (int w = sacl_pkg::WAYS - 1; w >= 0; w--) begin
			if (row[w].valid && row[w].tag == tag_s1) begin
				is_hit  = 1'b1;
				hit_way = sacl_pkg::WAY_W'(w);
			end
		end
		found   = 1'b0;
		vic_way = '0;
		least   = sacl_pkg::AGE_MAX;
		for (int w = 0; w < sacl_pkg::WAYS; w++) begin
			if (!found) begin
				if (!row[w].valid) begin
					vic_way = sacl_pkg::WAY_W'(w);
					found   = 1'b1;
				end else if (row[w].age < least) begin
					least   = row[w].age;
					vic_way = sacl_pkg::WAY_W'(w);
				end
			end
		end
		way = is_hit ? hit_way : vic_way;
		wb  = !is_hit && row[way].valid && row[way].dirty;

		new_row = row;
		for (int w = 0; w < sacl_pkg::WAYS; w++) begin
			if (sacl_pkg::WAY_W'(w) == way) begin
				new_row[w].age = sacl_pkg::AGE_MAX;
			end else if (row[w].age != '0) begin
				new_row[w].age = row[w].age - 1'b1;
			end
		end
		if (!is_hit) begin
			new_row[way].valid  = 1'b1;
			new_row[way].dirty  = 1'b0;
			new_row[way].tag    = tag_s1;
			new_row[way].filled = '0;
		end
		if (op_s1) begin
			new_row[way].dirty          = 1'b1;
			new_row[way].filled[off_s1] = 1'b1;
		end

		if (op_s1) begin
			rdata = wdata_s1;
		end else if (is_hit && row[way].filled[off_s1]) begin
			rdata = drow[way];
		end else begin
			rdata = '0;
		end

		lanes      = '0;
		lanes[way] = 1'b1;

		if (state_q == ST_CLEAR) begin
			tag_wr_en   = 1'b1;
			tag_wr_addr = clr_idx_q;
			tag_wr_data = '0;
		end else begin
			tag_wr_en   = (state_q == ST_LOOK);
			tag_wr_addr = idx_s1;
			tag_wr_data = new_row;
		end
	end

	sacl_tag_ram u_tag_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (in_idx),
		.rd_data (row),
		.wr_en   (tag_wr_en),
		.wr_addr (tag_wr_addr),
		.wr_data (tag_wr_data)
	);

	sacl_data_ram u_data_ram (
		.clk      (clk),
		.rd_en    (accept),
		.rd_addr  ({in_idx, in_off}),
		.rd_data  (drow),
		.wr_en    ((state_q == ST_LOOK) && op_s1),
		.wr_lanes (lanes),
		.wr_addr  ({idx_s1, off_s1}),
		.wr_data  (wdata_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
			penalty_q <= sacl_pkg::PENALTY_RESET;
			sum_q     <= '0;
			done      <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				penalty_q <= cfg_data;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == sacl_pkg::IDX_W'(sacl_pkg::SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_IDLE;
					done    <= 1'b1;
					if (!is_hit) begin
						sum_q <= sum_q + sacl_pkg::ADDR_W'(penalty_q);
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= operation;
			tag_s1   <= in_tag;
			idx_s1   <= in_idx;
			off_s1   <= in_off;
			wdata_s1 <= write_data;
		end
		if (state_q == ST_LOOK) begin
			read_data  <= rdata;
			hit        <= is_hit;
			chosen_way <= way;
			writeback  <= wb;
			writeback_addr <= wb ?
				{row[way].tag, idx_s1, (sacl_pkg::OFF_W + 2)'(0)} : '0;
			time_total <= is_hit ? sum_q : sum_q + sacl_pkg::ADDR_W'(penalty_q);
		end
	end

endmodule

// ===== rtl/sacl_checker.sv =====
// Port-level checker for set_assoc_cache_lru_counters, bound to the top.
// Depends on sacl_pkg for port widths.
module sacl_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic                        hit,
	input logic                        writeback,
	input logic [sacl_pkg::ADDR_W-1:0] writeback_addr
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_hit_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> !writeback)
		else $error("writeback reported on a hit");

	a_wb_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !writeback |-> writeback_addr == '0)
		else $error("writeback address without writeback");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

endmodule

bind set_assoc_cache_lru_counters sacl_checker u_sacl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.hit            (hit),
	.writeback      (writeback),
	.writeback_addr (writeback_addr)
);

// ===== tb/sv/tb_set_assoc_cache_lru_counters.sv =====
// Self-checking testbench for the set-associative write-back cache with age counters.
// Predicts every access result in a scoreboard class; depends on sacl_pkg and the RTL.
module tb_set_assoc_cache_lru_counters;
	timeunit 1ns;
	timeprecision 1ps;
	import sacl_pkg::*;

	localparam int MISS_LIMIT = 20000;
	localparam bit OP_READ  = 1'b0;
	localparam bit OP_WRITE = 1'b1;

	typedef struct packed {
		logic [DATA_W-1:0] rdata;
		logic              hit;
		logic [WAY_W-1:0]  way;
		logic              wb;
		logic [ADDR_W-1:0] wb_addr;
		logic [ADDR_W-1:0] total;
	} access_result_t;

	class cache_scoreboard;
		logic [TAG_W-1:0]  tags [SETS*WAYS];
		bit                valid [SETS*WAYS];
		bit                dirty [SETS*WAYS];
		logic [AGE_W-1:0]  age [SETS*WAYS];
		logic [DATA_W-1:0] words [SETS*WAYS*WORDS_PER_LINE];
		logic [ADDR_W-1:0] penalty_sum;
		logic [PEN_W-1:0]  penalty;
		access_result_t    pending [$];
		int                errors;

		function void clear();
			foreach (valid[i]) begin
				valid[i] = 0;
				dirty[i] = 0;
				age[i] = '0;
				tags[i] = '0;
			end
			penalty_sum = '0;
			penalty = PENALTY_RESET;
			errors = 0;
		endfunction

		function void note_access(bit op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wd);
			int unsigned off, set_no, base, way_no, slot, least;
			logic [TAG_W-1:0] tg;
			access_result_t r;
			off = addr[OFF_W+1:2];
			set_no = addr[IDX_W+OFF_W+1:OFF_W+2];
			tg = addr[ADDR_W-1:IDX_W+OFF_W+2];
			base = set_no * WAYS;
			r = '0;
			way_no = 0;
			for (int w = 0; w < WAYS; w++)
				if (!r.hit && valid[base+w] && tags[base+w] == tg) begin
					r.hit = 1;
					way_no = w;
				end
			if (!r.hit) begin
				penalty_sum += penalty;
				least = WAYS - 1;
				for (int w = 0; w < WAYS; w++) begin
					if (!valid[base+w]) begin
						way_no = w;
						break;
					end
					if (age[base+w] < least) begin
						least = age[base+w];
						way_no = w;
					end
				end
				if (valid[base+way_no] && dirty[base+way_no]) begin
					r.wb = 1;
					r.wb_addr = {tags[base+way_no], set_no[IDX_W-1:0], {(OFF_W+2){1'b0}}};
				end
				valid[base+way_no] = 1;
				dirty[base+way_no] = 0;
				tags[base+way_no] = tg;
				for (int k = 0; k < WORDS_PER_LINE; k++)
					words[(base+way_no)*WORDS_PER_LINE+k] = '0;
			end
			for (int w = 0; w < WAYS; w++)
				if (w == way_no) age[base+w] = AGE_MAX;
				else if (age[base+w] > 0) age[base+w]--;
			slot = (base + way_no) * WORDS_PER_LINE + off;
			if (op == OP_WRITE) begin
				words[slot] = wd;
				dirty[base+way_no] = 1;
			end
			r.rdata = words[slot];
			r.way = WAY_W'(way_no);
			r.total = penalty_sum;
			pending.push_back(r);
		endfunction

		function void check_result(access_result_t got);
			access_result_t exp;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("Unexpected result beat: %p", got);
				return;
			end
			exp = pending.pop_front();
			if (got !== exp) begin
				errors++;
				if (errors <= 10) $display("Mismatch: expected %p, got %p", exp, got);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic start = 0, operation = 0, cfg_valid = 0;
	logic [ADDR_W-1:0] address = '0;
	logic [DATA_W-1:0] write_data = '0;
	logic [PEN_W-1:0] cfg_data = '0;
	logic busy, cfg_ready, done, hit, writeback;
	logic [DATA_W-1:0] read_data;
	logic [WAY_W-1:0] chosen_way;
	logic [ADDR_W-1:0] writeback_addr, time_total;

	cache_scoreboard sb = new();
	int idle_pct, stall_cycles;
	logic [TAG_W-1:0] hot_tags [8];

	set_assoc_cache_lru_counters i_dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		if (done)
			sb.check_result('{read_data, hit, chosen_way, writeback, writeback_addr, time_total});
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles > MISS_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic issue_access(bit op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wd);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		operation <= op;
		address <= addr;
		write_data <= wd;
		do @(posedge clk); while (busy);
		sb.note_access(op, addr, wd);
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_penalty(logic [PEN_W-1:0] v);
		drain();
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.penalty = v;
		cfg_valid <= 0;
	endtask

	function automatic logic [ADDR_W-1:0] pick_addr();
		logic [ADDR_W-1:0] a;
		a = $urandom();
		if ($urandom_range(9) < 8) begin
			a[ADDR_W-1:IDX_W+OFF_W+2] = hot_tags[$urandom_range(7)];
			a[IDX_W+OFF_W+1:OFF_W+2] = IDX_W'($urandom_range(3));
		end
		return a;
	endfunction

	initial begin
		stall_cycles = 0;
		idle_pct = 0;
		sb.clear();
		foreach (hot_tags[i]) hot_tags[i] = TAG_W'($urandom());
		repeat (10) @(posedge clk);
		arst_n <= 1;

		issue_access(OP_READ, 32'h0000_0000, '0);
		issue_access(OP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_access(OP_READ, 32'hFFFF_FFFC, '0);
		issue_access(OP_WRITE, 32'h0000_0004, 32'hA5A5_5A5A);
		for (int t = 1; t <= 6; t++)
			issue_access(OP_WRITE, {TAG_W'(t), 8'h00, 5'h08}, 32'h1000 + t);
		for (int t = 0; t <= 6; t++)
			issue_access(OP_READ, {TAG_W'(t), 8'h00, 5'h08}, '0);
		issue_access(OP_WRITE, {TAG_W'(7), 8'h00, 5'h1C}, 32'h5555_AAAA);
		write_penalty('0);
		issue_access(OP_READ, {TAG_W'(9), 8'hFF, 5'h00}, '0);
		write_penalty(10'h3FF);
		issue_access(OP_WRITE, {TAG_W'(9), 8'h7F, 5'h10}, 32'h0);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 26 : (ph == 1) ? 78 : 0;
			write_penalty((ph == 2) ? PEN_W'(1) : PEN_W'($urandom()));
			for (int n = 0; n < 270; n++)
				issue_access(1'($urandom_range(1)), pick_addr(), $urandom());
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
